// File: src/module_response_line_parser_macros.svh
// Assertion helpers for the response line parser.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef MODULE_RESPONSE_LINE_PARSER_MACROS_SVH
`define MODULE_RESPONSE_LINE_PARSER_MACROS_SVH

// Checked on every rising clock edge, muted while reset is asserted.
`define RLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/rlp_pkg.sv
// Shared types and constants for the response line parser.
// No dependencies.
`timescale 1ns / 1ps

package rlp_pkg;

  localparam int unsigned LineMaxDef = 64;

  localparam logic [7:0] ChC  = 8'h43;
  localparam logic [7:0] ChA  = 8'h41;
  localparam logic [7:0] ChE  = 8'h45;
  localparam logic [7:0] ChM  = 8'h4D;
  localparam logic [7:0] ChO  = 8'h4F;
  localparam logic [7:0] ChD  = 8'h44;
  localparam logic [7:0] ChK  = 8'h4B;
  localparam logic [7:0] ChN  = 8'h4E;
  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChLf = 8'd10;

  typedef enum logic [2:0] {
    RESP_NONE = 3'd0,
    RESP_CMD  = 3'd1,
    RESP_AOK  = 3'd2,
    RESP_CONN = 3'd3,
    RESP_END  = 3'd4
  } resp_code_e;

  typedef enum logic [10:0] {
    MS_IDLE   = 11'b000_0000_0001,
    MS_C      = 11'b000_0000_0010,
    MS_CM     = 11'b000_0000_0100,
    MS_A      = 11'b000_0000_1000,
    MS_AO     = 11'b000_0001_0000,
    MS_CO     = 11'b000_0010_0000,
    MS_CON    = 11'b000_0100_0000,
    MS_E      = 11'b000_1000_0000,
    MS_EN     = 11'b001_0000_0000,
    MS_WAITCR = 11'b010_0000_0000,
    MS_WAITLF = 11'b100_0000_0000
  } match_state_e;

  typedef struct packed {
    logic       resp_valid;
    resp_code_e resp_code;
  } match_res_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_char;
    logic [6:0] char_position;
    logic       line_end;
    logic       line_overflow;
  } line_res_t;

endpackage

// File: src/rlp_match.sv
// Reply keyword matcher: byte-wise FSM for CMD, AOK, END (each +CR LF) and CONN.
// Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_match import rlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output match_res_t res_o
);

  match_state_e state_q, state_d;
  resp_code_e   pend_q, pend_d;
  resp_code_e   done;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    done    = RESP_NONE;
    unique case (state_q)
      MS_IDLE: begin
        pend_d = RESP_NONE;
        if (byte_i == ChC) state_d = MS_C;
        else if (byte_i == ChA) state_d = MS_A;
        else if (byte_i == ChE) state_d = MS_E;
      end
      MS_C: begin
        if (byte_i == ChM) state_d = MS_CM;
        else if (byte_i == ChO) state_d = MS_CO;
        else state_d = MS_IDLE;
      end
      MS_CM: begin
        if (byte_i == ChD) begin
          pend_d  = RESP_CMD;
          state_d = MS_WAITCR;
        end else begin
          state_d = MS_IDLE;
        end
      end
      MS_A: state_d = (byte_i == ChO) ? MS_AO : MS_IDLE;
      MS_AO: begin
        if (byte_i == ChK) begin
          pend_d  = RESP_AOK;
          state_d = MS_WAITCR;
        end else begin
          state_d = MS_IDLE;
        end
      end
      MS_CO: state_d = (byte_i == ChN) ? MS_CON : MS_IDLE;
      MS_CON: begin
        // CONN reports at its last letter, no CR LF needed
        if (byte_i == ChN) begin
          pend_d = RESP_CONN;
          done   = RESP_CONN;
        end
        state_d = MS_IDLE;
      end
      MS_E: state_d = (byte_i == ChN) ? MS_EN : MS_IDLE;
      MS_EN: begin
        if (byte_i == ChD) begin
          pend_d  = RESP_END;
          state_d = MS_WAITCR;
        end else begin
          state_d = MS_IDLE;
        end
      end
      MS_WAITCR: state_d = (byte_i == ChCr) ? MS_WAITLF : MS_IDLE;
      MS_WAITLF: begin
        if (byte_i == ChLf) done = pend_q;
        state_d = MS_IDLE;
      end
      default: state_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      pend_q  <= RESP_NONE;
    end else if (step_i) begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  assign res_o.resp_valid = (done != RESP_NONE);
  assign res_o.resp_code  = done;

endmodule

// File: src/rlp_line.sv
// Data-mode line collector: position counter, CR line end, overflow drop.
// Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_line import rlp_pkg::*; #(
  parameter int unsigned LineMax = LineMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output line_res_t  res_o
);

  localparam int unsigned PosW = $clog2(LineMax + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW+6:0] pos_ext;   // widened so the 7-bit report is a plain slice
  logic            is_cr;
  logic            has_room;

  assign is_cr    = (byte_i == ChCr);
  assign has_room = (pos_q < PosW'(LineMax));
  assign pos_ext  = {7'd0, pos_q};

  always_comb begin
    res_o = '0;
    pos_d = pos_q;
    if (is_cr) begin
      res_o.line_end      = 1'b1;
      res_o.char_position = pos_ext[6:0];
      pos_d               = '0;
    end else if (has_room) begin
      res_o.data_valid    = 1'b1;
      res_o.data_char     = byte_i;
      res_o.char_position = pos_ext[6:0];
      pos_d               = pos_q + PosW'(1);
    end else begin
      res_o.line_overflow = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: src/module_response_line_parser.sv
// Response line parser for a serial module link.
// Byte beats enter on in_valid_i/in_ready_o with rx_byte_i; one result beat
// leaves on out_valid_o/out_ready_i for every input beat, in order.
// Mode register: cfg_valid_i/cfg_ready_o with command_mode_i, always ready.
// Write it only while no beat is in flight.
// command_mode = 1: keyword matcher reports CMD, AOK, END (after CR LF) and
// CONN (at its fourth letter) on response_valid_o/response_code_o.
// command_mode = 0: bytes are line characters with their position; CR gives
// line_end_o with the length; beyond LINE_MAX a byte is dropped with
// line_overflow_o.
// Pipeline: input register, then combinational decode into the result
// register. out_valid_o rises once the beat has moved from the input register
// into the result register; sustained rate is one beat per cycle while
// out_ready_i stays high.
// in_ready_o stays high while the result register drains or is empty, so a
// stalled receiver holds at most two beats (input and result registers).
// Reset clears both registers' valid bits, sets command mode, the matcher to
// idle and the line position to zero. Mode changes clear no state.
// Depends on rlp_pkg, rlp_match, rlp_line and the macros header.
`timescale 1ns / 1ps
`include "module_response_line_parser_macros.svh"

module module_response_line_parser import rlp_pkg::*; #(
  parameter int unsigned LINE_MAX = LineMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // mode register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       command_mode_i,
  // byte input
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       response_valid_o,
  output logic [2:0] response_code_o,
  output logic       data_valid_o,
  output logic [7:0] data_char_o,
  output logic [6:0] char_position_o,
  output logic       line_end_o,
  output logic       line_overflow_o
);

  logic       mode_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       advance;      // input register moves into the result register

  match_res_t match_res;
  line_res_t  line_res;
  match_res_t match_sel;
  line_res_t  line_sel;

  match_res_t resp_q;
  line_res_t  line_q;

  assign cfg_ready_o = 1'b1;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      mode_q <= command_mode_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // each unit only steps in its own mode
  rlp_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance && mode_q),
    .byte_i (in_byte_q),
    .res_o  (match_res)
  );

  rlp_line #(
    .LineMax (LINE_MAX)
  ) u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance && !mode_q),
    .byte_i (in_byte_q),
    .res_o  (line_res)
  );

  // fields of the inactive mode read as zero
  assign match_sel = mode_q ? match_res : '0;
  assign line_sel  = mode_q ? '0 : line_res;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      resp_q <= match_sel;
      line_q <= line_sel;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign response_valid_o = resp_q.resp_valid;
  assign response_code_o  = resp_q.resp_code;
  assign data_valid_o     = line_q.data_valid;
  assign data_char_o      = line_q.data_char;
  assign char_position_o  = line_q.char_position;
  assign line_end_o       = line_q.line_end;
  assign line_overflow_o  = line_q.line_overflow;

  // a held byte is not overwritten while the result side is stalled
  `RLP_ASSERT(a_in_hold, in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q), "input register lost a beat")
  // a reply result never carries data-mode fields
  `RLP_ASSERT(a_mode_excl, out_valid_q && response_valid_o |-> !data_valid_o && !line_end_o && !line_overflow_o, "reply and line fields both set")
  // valid flag and code agree
  `RLP_ASSERT(a_code_flag, out_valid_q |-> (response_valid_o == (response_code_o != RESP_NONE)), "response code and flag disagree")
  // at most one data-mode outcome per beat
  `RLP_ASSERT(a_line_onehot, out_valid_q |-> $onehot0({data_valid_o, line_end_o, line_overflow_o}), "more than one line outcome")

endmodule

// File: sim/tb_module_response_line_parser.sv
// Self-checking testbench for module_response_line_parser: keyword replies in
// command mode, line characters, line ends and overflow in data mode.
// Depends on rlp_pkg and the module_response_line_parser RTL only.
`timescale 1ns / 1ps

module tb_module_response_line_parser;
  import rlp_pkg::*;

  // One result beat as the block presents it.
  typedef struct packed {
    logic       resp_valid;
    logic [2:0] resp_code;
    logic       data_valid;
    logic [7:0] data_char;
    logic [6:0] char_pos;
    logic       line_end;
    logic       line_overflow;
  } parse_result_t;

  // DUT signals; every input starts at a known value.
  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_valid_i    = 1'b0;
  logic       cfg_ready_o;
  logic       command_mode_i = 1'b1;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i      = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic       response_valid_o;
  logic [2:0] response_code_o;
  logic       data_valid_o;
  logic [7:0] data_char_o;
  logic [6:0] char_position_o;
  logic       line_end_o;
  logic       line_overflow_o;

  // Shadow copy of the block's state, starting from its reset values.
  logic         mode_shadow = 1'b1;
  match_state_e kw_state = MS_IDLE;
  resp_code_e   held_code = RESP_NONE;
  int unsigned  line_len = 0;

  parse_result_t parse_results_q[$];  // predicted beats, oldest first
  int            mismatches = 0;
  int            sent_bytes = 0;
  logic          steady     = 1'b0;   // 1: neither side inserts gaps

  string reply_words[4] = '{"CMD", "AOK", "END", "CONN"};

  module_response_line_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .command_mode_i  (command_mode_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .response_valid_o(response_valid_o),
    .response_code_o (response_code_o),
    .data_valid_o    (data_valid_o),
    .data_char_o     (data_char_o),
    .char_position_o (char_position_o),
    .line_end_o      (line_end_o),
    .line_overflow_o (line_overflow_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Safety net: the slowest legal run is far shorter than this.
  initial begin
    #400_000;
    $display("tb_module_response_line_parser: errors");
    $finish;
  end

  // Predicts the result beat for one accepted byte and advances the shadow
  // state. Matcher state and line length each belong to one mode only.
  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    resp_code_e    done;
    r    = '0;
    done = RESP_NONE;
    if (mode_shadow) begin
      case (kw_state)
        MS_IDLE: begin
          // idle forgets any reply still waiting for CR LF
          held_code = RESP_NONE;
          if (b == ChC) kw_state = MS_C;
          else if (b == ChA) kw_state = MS_A;
          else if (b == ChE) kw_state = MS_E;
        end
        MS_C: begin
          if (b == ChM) kw_state = MS_CM;
          else if (b == ChO) kw_state = MS_CO;
          else kw_state = MS_IDLE;
        end
        MS_CM: begin
          if (b == ChD) begin
            held_code = RESP_CMD;
            kw_state  = MS_WAITCR;
          end else kw_state = MS_IDLE;
        end
        MS_A: begin
          if (b == ChO) kw_state = MS_AO;
          else kw_state = MS_IDLE;
        end
        MS_AO: begin
          if (b == ChK) begin
            held_code = RESP_AOK;
            kw_state  = MS_WAITCR;
          end else kw_state = MS_IDLE;
        end
        MS_CO: begin
          if (b == ChN) kw_state = MS_CON;
          else kw_state = MS_IDLE;
        end
        MS_CON: begin
          // CONN reports on its fourth letter, no CR LF needed
          if (b == ChN) begin
            held_code = RESP_CONN;
            done      = RESP_CONN;
          end
          kw_state = MS_IDLE;
        end
        MS_E: begin
          if (b == ChN) kw_state = MS_EN;
          else kw_state = MS_IDLE;
        end
        MS_EN: begin
          if (b == ChD) begin
            held_code = RESP_END;
            kw_state  = MS_WAITCR;
          end else kw_state = MS_IDLE;
        end
        MS_WAITCR: begin
          if (b == ChCr) kw_state = MS_WAITLF;
          else kw_state = MS_IDLE;
        end
        MS_WAITLF: begin
          if (b == ChLf) done = held_code;
          kw_state = MS_IDLE;
        end
        default: kw_state = MS_IDLE;
      endcase
      r.resp_valid = (done != RESP_NONE);
      r.resp_code  = done;
    end else if (b == ChCr) begin
      // line end carries the length, empty lines included
      r.char_pos = line_len[6:0];
      r.line_end = 1'b1;
      line_len   = 0;
    end else if (line_len < LineMaxDef) begin
      r.data_valid = 1'b1;
      r.data_char  = b;
      r.char_pos   = line_len[6:0];
      line_len++;
    end else begin
      // line full: byte dropped, reported position is 0
      r.line_overflow = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: ready drops with a 16 percent chance unless in a steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Every result beat is compared against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parse_results_q.size() == 0) begin
        $display("%0t ns: result beat with nothing predicted, expected none, actual %0h",
                 $time, {response_valid_o, response_code_o, data_valid_o, data_char_o,
                         char_position_o, line_end_o, line_overflow_o});
        mismatches++;
      end else begin
        want = parse_results_q.pop_front();
        check_field("response_valid", want.resp_valid,    response_valid_o);
        check_field("response_code",  want.resp_code,     response_code_o);
        check_field("data_valid",     want.data_valid,    data_valid_o);
        check_field("data_char",      want.data_char,     data_char_o);
        check_field("char_position",  want.char_pos,      char_position_o);
        check_field("line_end",       want.line_end,      line_end_o);
        check_field("line_overflow",  want.line_overflow, line_overflow_o);
      end
    end
  end

  // Sends one byte beat; valid holds until the beat is taken. The prediction
  // is made at the accepting edge, with the mode in force then.
  task automatic send_byte(input logic [7:0] b);
    if (!steady) begin
      while ($urandom_range(0, 99) < 16) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    parse_results_q.push_back(parse_byte(b));
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Keyword plus its CR LF terminator; CONN has none.
  task automatic send_reply(input string kw);
    send_text(kw);
    if (kw != "CONN") begin
      send_byte(ChCr);
      send_byte(ChLf);
    end
  endtask

  // Mode writes only with nothing in flight; each byte yields a beat, so an
  // empty prediction queue plus the pipeline depth means the block is idle.
  task automatic write_mode(input logic m);
    in_valid_i <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    command_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_shadow = m;
  endtask

  // Any byte except CR, so data lines only end where intended.
  function automatic logic [7:0] line_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == ChCr) b = ChLf;
    return b;
  endfunction

  // All four replies, well formed, back to back.
  task automatic test_reply_keywords();
    int i;
    for (i = 0; i < 4; i++) send_reply(reply_words[i]);
  endtask

  // Empty line, then the byte extremes as line characters.
  task automatic test_data_line_edges();
    write_mode(1'b0);
    send_byte(ChCr);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChCr);
  endtask

  // Mode changes keep both the partial match and the line position.
  task automatic test_mode_switch_keeps_state();
    write_mode(1'b1);
    send_text("CM");
    write_mode(1'b0);
    send_byte(8'h61);
    write_mode(1'b1);
    send_byte(ChD);
    send_byte(ChCr);
    send_byte(ChLf);
  endtask

  // Mostly valid replies; the rest are broken prefixes, missing LF and noise.
  task automatic test_random_reply_stream(input int count);
    int    target;
    int    pick;
    int    k;
    int    n;
    string kw;
    target = sent_bytes + count;
    while (sent_bytes < target) begin
      pick = $urandom_range(0, 99);
      kw   = reply_words[$urandom_range(0, 3)];
      if (pick < 60) begin
        send_reply(kw);
      end else if (pick < 75) begin
        // cut a keyword short and break it with an arbitrary byte
        k = $urandom_range(1, kw.len() - 1);
        send_text(kw.substr(0, k - 1));
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        // CR not followed by LF
        send_text(reply_words[$urandom_range(0, 2)]);
        send_byte(ChCr);
        send_byte(8'($urandom_range(11, 255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
    end
    // sometimes leave a partial keyword across the next mode change
    if ($urandom_range(0, 1) == 1) send_text(kw.substr(0, 1));
  endtask

  // Text lines of random length; about one in five is near the line limit, some past it.
  task automatic test_random_data_lines(input int count);
    int target;
    int n;
    target = sent_bytes + count;
    while (sent_bytes < target) begin
      if ($urandom_range(0, 4) == 0) n = $urandom_range(LineMaxDef - 4, LineMaxDef + 6);
      else n = $urandom_range(0, 12);
      repeat (n) send_byte(line_char());
      // an open line is carried across the mode change now and then
      if (sent_bytes < target || $urandom_range(0, 1) == 1) send_byte(ChCr);
    end
  endtask

  initial begin
    int ph;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reply_keywords();
    test_data_line_edges();
    test_mode_switch_keeps_state();

    // Alternating random phases; one pair runs with no gaps on either side.
    for (ph = 0; ph < 5; ph++) begin
      steady = (ph == 2);
      write_mode(1'b1);
      test_random_reply_stream(40);
      write_mode(1'b0);
      test_random_data_lines(40);
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_module_response_line_parser: clean");
    end else begin
      $display("tb_module_response_line_parser: errors");
    end
    $finish;
  end

endmodule
